FILE: rtl/dips_pkg.sv
// Shared types and constants for the dual incremental PI step unit.
// Used by the controller, the datapath, the top level and the checker.
package dips_pkg;

  localparam int SIGNAL_WIDTH_DEF = 32;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_KP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_KI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_KP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_KI     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 3'd6;

  // 195.0 and 20.0 in Q16.16
  localparam logic [23:0] VOLT_MAX     = 24'd12779520;
  localparam logic [23:0] VOLT_RESTART = 24'd1310720;
  localparam logic [5:0]  STARTUP_TICKS = 6'd50;
  localparam logic [5:0]  STARTUP_DONE  = 6'd55;

  localparam logic LOOP_VOLTAGE = 1'b0;
  localparam logic LOOP_CURRENT = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_KT,
    OP_P,
    OP_IH,
    OP_IL,
    OP_ACC,
    OP_SUM,
    OP_UPD,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic loop;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

FILE: rtl/dips_ctrl.sv
// Sequencer for the dual incremental PI step unit.
// Depends on dips_pkg; drives the datapath through cmd_t, reads status_t.
module dips_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dips_pkg::status_t status_i,
  output dips_pkg::cmd_t    cmd_o
);
  import dips_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_KT   = 4'd1;
  localparam logic [3:0] ST_P    = 4'd2;
  localparam logic [3:0] ST_IH   = 4'd3;
  localparam logic [3:0] ST_IL   = 4'd4;
  localparam logic [3:0] ST_ACC  = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_UPD  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       loop_q, loop_d;

  always_comb begin
    state_d   = state_q;
    loop_d    = loop_q;
    cmd_o.op   = OP_NONE;
    cmd_o.loop = loop_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          loop_d   = LOOP_VOLTAGE;
          state_d  = ST_KT;
        end
      end
      ST_KT: begin
        cmd_o.op = OP_KT;
        state_d  = ST_P;
      end
      ST_P: begin
        cmd_o.op = OP_P;
        state_d  = ST_IH;
      end
      ST_IH: begin
        cmd_o.op = OP_IH;
        state_d  = ST_IL;
      end
      ST_IL: begin
        cmd_o.op = OP_IL;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.op = OP_UPD;
        if (loop_q == LOOP_VOLTAGE) begin
          loop_d  = LOOP_CURRENT;
          state_d = ST_KT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      loop_q  <= LOOP_VOLTAGE;
    end else begin
      state_q <= state_d;
      loop_q  <= loop_d;
    end
  end

endmodule

FILE: rtl/dips_datapath.sv
// Datapath for the dual incremental PI step unit: registers, loop state,
// one shared multiplier, accumulators and the output word. Depends on dips_pkg.
module dips_datapath #(
  parameter int SIGNAL_WIDTH = dips_pkg::SIGNAL_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dips_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic signed [31:0]             measured_voltage_i,
  input  logic signed [31:0]             measured_current_i,
  input  dips_pkg::cmd_t                 cmd_i,
  output dips_pkg::status_t              status_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [23:0]                    voltage_drive_o,
  output logic signed [31:0]             current_drive_o,
  output logic                           integral_active_o
);
  import dips_pkg::*;

  localparam int W  = SIGNAL_WIDTH;
  localparam int AW = W + 1;
  localparam int PW = W + 18;
  localparam int IW = W + 34;
  localparam int SW = W + 12;
  localparam int EW = (W > 33) ? W : 33;

  localparam logic signed [EW-1:0] E_MAX = EW'($signed({1'b0, {(W-1){1'b1}}}));
  localparam logic signed [EW-1:0] E_MIN = EW'($signed({1'b1, {(W-1){1'b0}}}));
  localparam logic signed [SW-1:0] S_MAX = SW'($signed({1'b0, {(W-1){1'b1}}}));
  localparam logic signed [SW-1:0] S_MIN = SW'($signed({1'b1, {(W-1){1'b0}}}));
  localparam logic signed [SW-1:0] U_MAX = $signed(SW'(VOLT_MAX));

  function automatic logic signed [W-1:0] err_sat(input logic signed [31:0] tgt,
                                                  input logic signed [31:0] meas);
    logic signed [32:0]   d33;
    logic signed [EW-1:0] d;
    d33 = 33'(tgt) - 33'(meas);
    d   = EW'(d33);
    if (d > E_MAX) begin
      return W'(E_MAX);
    end else if (d < E_MIN) begin
      return W'(E_MIN);
    end
    return W'(d);
  endfunction

  // configuration
  logic signed [31:0] vt_q, ct_q;
  logic [15:0]        vkp_q, vki_q, ckp_q, cki_q, per_q;

  // loop state
  logic signed [W-1:0] ve_q, ce_q, prev_ve_q, prev_ce_q, cacc_q;
  logic [23:0]         vacc_q;
  logic                ven_q;
  logic [5:0]          cnt_q;

  // work registers
  logic [31:0]          kt_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [SW-1:0] p_q, u_q;
  logic signed [IW-1:0] i_q;

  // output word
  logic                out_valid_q;
  logic [23:0]         vdrv_q;
  logic signed [31:0]  cdrv_q;
  logic                iact_q;

  logic signed [W-1:0]  err, prev;
  logic [15:0]          kp, ki;
  logic signed [SW-1:0] acc_ext, iterm;
  logic signed [AW-1:0] delta, mul_a;
  logic [15:0]          mul_b;
  logic                 use_i, over, under;

  always_comb begin
    if (cmd_i.loop == LOOP_CURRENT) begin
      err     = ce_q;
      prev    = prev_ce_q;
      kp      = ckp_q;
      ki      = cki_q;
      acc_ext = SW'(cacc_q);
    end else begin
      err     = ve_q;
      prev    = prev_ve_q;
      kp      = vkp_q;
      ki      = vki_q;
      acc_ext = SW'($signed({1'b0, vacc_q}));
    end
    delta = AW'(err) - AW'(prev);
    use_i = (cmd_i.loop == LOOP_CURRENT) || ven_q;
    iterm = use_i ? SW'(i_q >>> 24) : '0;
    over  = (u_q > U_MAX);
    under = u_q[SW-1];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_KT: begin
        mul_a = AW'($signed({1'b0, ki}));
        mul_b = per_q;
      end
      OP_P: begin
        mul_a = delta;
        mul_b = kp;
      end
      OP_IH: begin
        mul_a = AW'(err);
        mul_b = kt_q[31:16];
      end
      OP_IL: begin
        mul_a = AW'(err);
        mul_b = kt_q[15:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = PW'(mul_a) * PW'($signed({1'b0, mul_b}));
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (cmd_i.op)
      OP_LOAD: begin
        ve_q <= err_sat(vt_q, measured_voltage_i);
        ce_q <= err_sat(ct_q, measured_current_i);
      end
      OP_P:    kt_q <= prod_q[31:0];
      OP_IH:   p_q  <= acc_ext + SW'(prod_q >>> 8);
      OP_IL:   i_q  <= IW'(prod_q) <<< 16;
      OP_ACC:  i_q  <= i_q + IW'(prod_q);
      OP_SUM:  u_q  <= p_q + iterm;
      OP_OUT: begin
        vdrv_q <= vacc_q;
        cdrv_q <= 32'(cacc_q);
        iact_q <= ven_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q  <= '0;
      ct_q  <= '0;
      vkp_q <= '0;
      vki_q <= '0;
      ckp_q <= '0;
      cki_q <= '0;
      per_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_VOLTAGE_TARGET: vt_q  <= cfg_data_i;
        REG_CURRENT_TARGET: ct_q  <= cfg_data_i;
        REG_VOLTAGE_KP:     vkp_q <= cfg_data_i[15:0];
        REG_VOLTAGE_KI:     vki_q <= cfg_data_i[15:0];
        REG_CURRENT_KP:     ckp_q <= cfg_data_i[15:0];
        REG_CURRENT_KI:     cki_q <= cfg_data_i[15:0];
        REG_SAMPLE_PERIOD:  per_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ve_q <= '0;
      prev_ce_q <= '0;
      vacc_q    <= '0;
      cacc_q    <= '0;
      ven_q     <= 1'b1;
      cnt_q     <= '0;
    end else if (cmd_i.op == OP_UPD) begin
      if (cmd_i.loop == LOOP_VOLTAGE) begin
        prev_ve_q <= ve_q;
        if (over) begin
          vacc_q <= (cnt_q < STARTUP_TICKS) ? VOLT_RESTART : VOLT_MAX;
        end else if (under) begin
          vacc_q <= '0;
        end else begin
          vacc_q <= u_q[23:0];
        end
        // anti-windup looks at the unclamped sum
        ven_q <= !((over && !ve_q[W-1] && (ve_q != '0)) || (under && ve_q[W-1]));
        if (over && (cnt_q < STARTUP_TICKS)) begin
          cnt_q <= STARTUP_DONE;
        end else if (cnt_q < STARTUP_TICKS) begin
          cnt_q <= cnt_q + 6'd1;
        end
      end else begin
        prev_ce_q <= ce_q;
        if (u_q > S_MAX) begin
          cacc_q <= W'(S_MAX);
        end else if (u_q < S_MIN) begin
          cacc_q <= W'(S_MIN);
        end else begin
          cacc_q <= W'(u_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign voltage_drive_o    = vdrv_q;
  assign current_drive_o    = cdrv_q;
  assign integral_active_o  = iact_q;

endmodule

FILE: rtl/dual_incremental_pi_step_unit.sv
// Top level of the dual incremental PI step unit.
// Depends on dips_pkg, dips_ctrl and dips_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word per sample tick:
//   measured voltage and current, signed Q16.16. Output channel
//   (out_valid_o / out_stall_i) returns one word per tick: clamped voltage
//   drive, saturated current drive and the voltage integral enable.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken; write
//   them only while no tick is in flight. Index 7 is ignored.
// Timing:
//   A tick is accepted only while the unit is idle, and the unit stays busy until its
//   result word is handed to the output register; only then is the next word accepted.
//   The serial schedule follows from the single shared multiplier: the unit runs seven
//   steps per loop for the two loops in turn.
// Reset and stall:
//   Reset clears the configuration, previous errors, accumulators and the start-up
//   window, and sets the integral enable. A result word waits in the output
//   register while the receiver stalls; the next tick may be accepted and
//   computed meanwhile, and holds in its last step until the output register frees up.
module dual_incremental_pi_step_unit #(
  parameter int SIGNAL_WIDTH = dips_pkg::SIGNAL_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dips_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             measured_voltage_i,
  input  logic signed [31:0]             measured_current_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [23:0]                    voltage_drive_o,
  output logic signed [31:0]             current_drive_o,
  output logic                           integral_active_o
);
  import dips_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  dips_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dips_datapath #(
    .SIGNAL_WIDTH (SIGNAL_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .measured_voltage_i (measured_voltage_i),
    .measured_current_i (measured_current_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .voltage_drive_o    (voltage_drive_o),
    .current_drive_o    (current_drive_o),
    .integral_active_o  (integral_active_o)
  );

endmodule

FILE: rtl/dips_checker.sv
// Port-level checks for the dual incremental PI step unit, bound to the top.
// Depends on dips_pkg.
module dips_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [23:0]        voltage_drive_o,
  input logic signed [31:0] current_drive_o,
  input logic               integral_active_o
);
  import dips_pkg::*;

  // busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // a result only appears after a busy period
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without preceding work");

  a_voltage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (voltage_drive_o <= VOLT_MAX))
    else $error("voltage drive above limit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(voltage_drive_o)
      && $stable(current_drive_o) && $stable(integral_active_o)))
    else $error("stalled result word changed");

endmodule

bind dual_incremental_pi_step_unit dips_checker u_dips_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .voltage_drive_o   (voltage_drive_o),
  .current_drive_o   (current_drive_o),
  .integral_active_o (integral_active_o)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for dual_incremental_pi_step_unit: directed and random ticks
// against a built-in predictor of both PI loops. Depends on dips_pkg and the RTL.
module tb;
  import dips_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic [23:0]        voltage;
    logic signed [31:0] current;
    logic               integ;
  } drive_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [31:0]   measured_voltage_i;
  logic signed [31:0]   measured_current_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [23:0]          voltage_drive_o;
  logic signed [31:0]   current_drive_o;
  logic                 integral_active_o;

  dual_incremental_pi_step_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .measured_voltage_i (measured_voltage_i),
    .measured_current_i (measured_current_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .voltage_drive_o    (voltage_drive_o),
    .current_drive_o    (current_drive_o),
    .integral_active_o  (integral_active_o)
  );

  // Predictor copy of registers and loop state
  logic signed [31:0] v_target, c_target;
  logic [15:0]        v_kp, v_ki, c_kp, c_ki, period;
  wide_t              v_prev_err, v_accum, c_prev_err, c_accum;
  logic               v_integ_en;
  logic [5:0]         startup_cnt;

  drive_word_t drive_q[$];
  int          mismatch_cnt;
  int          words_seen;
  int          idle_cycles;
  int          burst_left;
  bit          gaps_on;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_loops();
    v_target = '0; c_target = '0;
    v_kp = '0; v_ki = '0; c_kp = '0; c_ki = '0; period = '0;
    v_prev_err = '0; v_accum = '0; c_prev_err = '0; c_accum = '0;
    v_integ_en = 1'b1;
    startup_cnt = '0;
  endfunction

  function automatic wide_t clamp_signal(wide_t x);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (SIGNAL_WIDTH_DEF - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // floor(delta * kp / 2^8)
  function automatic wide_t prop_gain(wide_t delta, logic [15:0] kp);
    wide_t k;
    k = kp;
    return (delta * k) >>> 8;
  endfunction

  // floor(err * ki * t / 2^24)
  function automatic wide_t integ_gain(wide_t err, logic [15:0] ki, logic [15:0] t);
    wide_t kt;
    kt = ki * t;
    return (err * kt) >>> 24;
  endfunction

  function automatic drive_word_t step_pi_loops(logic signed [31:0] mv,
                                                logic signed [31:0] mc);
    wide_t ve, ce, u, c, tgt, meas, vmax;
    drive_word_t w;
    vmax = VOLT_MAX;
    tgt = v_target; meas = mv;
    ve = clamp_signal(tgt - meas);
    tgt = c_target; meas = mc;
    ce = clamp_signal(tgt - meas);

    u = v_accum + prop_gain(ve - v_prev_err, v_kp);
    if (v_integ_en) u = u + integ_gain(ve, v_ki, period);
    v_prev_err = ve;
    if (u > vmax) begin
      if (startup_cnt < STARTUP_TICKS) begin
        v_accum = VOLT_RESTART;
        startup_cnt = STARTUP_DONE;
      end else begin
        v_accum = vmax;
      end
    end else if (u < 0) begin
      v_accum = '0;
    end else begin
      v_accum = u;
    end
    v_integ_en = !((u > vmax && ve > 0) || (u < 0 && ve < 0));

    c = c_accum + prop_gain(ce - c_prev_err, c_kp) + integ_gain(ce, c_ki, period);
    c_accum = clamp_signal(c);
    c_prev_err = ce;

    if (startup_cnt < STARTUP_TICKS) startup_cnt = startup_cnt + 6'd1;

    w.voltage = v_accum[23:0];
    w.current = c_accum[31:0];
    w.integ   = v_integ_en;
    return w;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // mostly near the setpoint, some full-range and some extremes
  function automatic logic [31:0] pick_meas(logic [31:0] tgt);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom;
    if (sel == 1) return pick_extreme();
    return tgt + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 16'h0200));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_VOLTAGE_TARGET: v_target = data;
      REG_CURRENT_TARGET: c_target = data;
      REG_VOLTAGE_KP:     v_kp = data[15:0];
      REG_VOLTAGE_KI:     v_ki = data[15:0];
      REG_CURRENT_KP:     c_kp = data[15:0];
      REG_CURRENT_KI:     c_ki = data[15:0];
      REG_SAMPLE_PERIOD:  period = data[15:0];
      default: ;
    endcase
  endtask

  // 16-bit registers get random upper bits, which must be ignored
  task automatic write_all_regs(input logic [31:0] vt, input logic [31:0] ct,
                                input logic [15:0] vkp, input logic [15:0] vki,
                                input logic [15:0] ckp, input logic [15:0] cki,
                                input logic [15:0] t);
    write_reg(REG_VOLTAGE_TARGET, vt);
    write_reg(REG_CURRENT_TARGET, ct);
    write_reg(REG_VOLTAGE_KP, {16'($urandom), vkp});
    write_reg(REG_VOLTAGE_KI, {16'($urandom), vki});
    write_reg(REG_CURRENT_KP, {16'($urandom), ckp});
    write_reg(REG_CURRENT_KI, {16'($urandom), cki});
    write_reg(REG_SAMPLE_PERIOD, {16'($urandom), t});
  endtask

  task automatic send_sample(input logic [31:0] mv, input logic [31:0] mc);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i         <= 1'b1;
    measured_voltage_i <= mv;
    measured_current_i <= mc;
    do @(posedge clk_i); while (in_stall_o);
    drive_q.push_back(step_pi_loops(mv, mc));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // reset values: zero gains keep both outputs at zero
  task automatic test_zero_gains();
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001);
    wait_drained();
  endtask

  // first overflow inside the start-up window restarts at 20, later ones clamp
  // at 195; windup disable in both directions; current saturates both ways
  task automatic test_startup_window();
    write_reg(REG_NONE, $urandom);
    write_all_regs(32'h0, 32'h0, 16'h0100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (4) send_sample(32'h8000_0000, 32'h8000_0000);
    repeat (3) send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_all_regs(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'h0000,
                   16'h0000, 16'hFFFF, 16'hFFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001);
    wait_drained();
    write_all_regs(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 16'hFFFF,
                   16'hFFFF, 16'h0000, 16'h0000);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h0000_0000, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();
  endtask

  // receiver holds off long enough for the unit to back up into its input
  task automatic test_output_hold();
    write_all_regs(32'd100 << 16, 32'd5 << 16, 16'h0080, 16'h0100,
                   16'h0040, 16'h0100, 16'h0800);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (8) send_sample(pick_meas(v_target), pick_meas(c_target));
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_all_regs(32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        1: write_all_regs(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: begin
          write_all_regs(($urandom_range(0, 1) != 0) ?
                           (32'($urandom_range(0, 200)) << 16) | 32'($urandom_range(0, 16'hFFFF)) :
                           $urandom,
                         $urandom_range(0, 32'h0080_0000) - 32'h0040_0000,
                         pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain());
          if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, $urandom);
        end
      endcase
      gaps_on = (phase % 3) != 2;
      repeat (160) send_sample(pick_meas(v_target), pick_meas(c_target));
      wait_drained();
    end
  endtask

  // receiver stall pattern
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= $urandom_range(0, 1);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (mode_left % 8) < 6;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    drive_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("tb: unexpected word %0d: voltage_drive %h current_drive %h integral %b",
                   words_seen, voltage_drive_o, current_drive_o, integral_active_o);
      end else begin
        exp_w = drive_q.pop_front();
        if (voltage_drive_o !== exp_w.voltage || current_drive_o !== exp_w.current ||
            integral_active_o !== exp_w.integ) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("tb: word %0d: voltage_drive exp %h got %h, current_drive exp %h got %h, integral exp %b got %b",
                     words_seen, exp_w.voltage, voltage_drive_o, exp_w.current,
                     current_drive_o, exp_w.integ, integral_active_o);
        end
      end
      words_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    measured_voltage_i = '0;
    measured_current_i = '0;
    mismatch_cnt = 0;
    words_seen = 0;
    idle_cycles = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    clear_loops();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_zero_gains();
    test_startup_window();
    test_register_extremes();
    test_output_hold();
    test_random_phases();

    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: dual_incremental_pi_step_unit.f
rtl/dips_pkg.sv
rtl/dips_ctrl.sv
rtl/dips_datapath.sv
rtl/dual_incremental_pi_step_unit.sv
rtl/dips_checker.sv
sim/tb.sv
